@@ design/rbsi_pkg.sv @@
// Shared constants and types of the ray versus box slab intersection unit.
package rbsi_pkg;

   // Default fixed-point format: signed Q16.16.
   localparam int COORD_WIDTH_DEF = 32;
   localparam int FRAC_BITS_DEF   = 16;

   // Configuration register indexes.
   localparam int CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_X = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Y = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MIN_Z = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_X = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Y = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOX_MAX_Z = 3'd5;

   // Entry face codes: min faces are the axis, max faces add this offset.
   localparam int FACE_W = 3;
   localparam logic [FACE_W-1:0] FACE_MAX_OFFSET = 3'd3;

   // Flags that ride alongside the dividers, with zero_dir per axis.
   typedef struct packed {
      logic [2:0] zero_dir;   // direction within epsilon of zero
      logic       slab_miss;  // origin outside a slab of a near-zero axis
   } side_type;

endpackage

@@ design/rbsi_divider.sv @@
// Pipelined restoring divider giving a saturated signed fixed-point quotient.
module rbsi_divider #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          advance,
   input  logic [COORD_WIDTH:0]          num_mag,
   input  logic [COORD_WIDTH-1:0]        den_mag,
   input  logic                          neg,
   output logic signed [COORD_WIDTH-1:0] quotient
);

   localparam int NW = COORD_WIDTH + 1;
   localparam int DW = COORD_WIDTH;
   localparam int QB = NW + FRAC_BITS;
   localparam int QL = COORD_WIDTH - 1;
   localparam logic signed [COORD_WIDTH-1:0] FMT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] FMT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   logic [DW-1:0] rem_ff  [0:QB];
   logic [NW-1:0] nmag_ff [0:QB];
   logic [DW-1:0] dm_ff   [0:QB];
   logic          neg_ff  [0:QB];
   logic          sat_ff  [0:QB];
   logic [QL-1:0] q_ff    [0:QB];
   logic signed [COORD_WIDTH-1:0] quot_ff;
   logic signed [COORD_WIDTH-1:0] quot_in;
   logic        [COORD_WIDTH-1:0] q_pos;

   // Load stage.
   always_ff @(posedge clock) begin
      if (advance) begin
         rem_ff[0]  <= '0;
         nmag_ff[0] <= num_mag;
         dm_ff[0]   <= den_mag;
         neg_ff[0]  <= neg;
         sat_ff[0]  <= 1'b0;
         q_ff[0]    <= '0;
      end
   end

   // One quotient bit per stage, most significant first.
   for (genvar k = 0; k < QB; k++) begin : g_step
      localparam int  P    = QB - 1 - k;
      localparam bit  HIGH = (P >= COORD_WIDTH - 1);
      logic          nbit;
      logic [DW:0]   shifted;
      logic [DW:0]   trial;
      logic          take;

      if (P >= FRAC_BITS) begin : g_nbit
         assign nbit = nmag_ff[k][P-FRAC_BITS];
      end else begin : g_zero
         assign nbit = 1'b0;
      end

      assign shifted = {rem_ff[k], nbit};
      assign take    = shifted >= {1'b0, dm_ff[k]};
      assign trial   = shifted - {1'b0, dm_ff[k]};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k+1]  <= take ? trial[DW-1:0] : shifted[DW-1:0];
            nmag_ff[k+1] <= nmag_ff[k];
            dm_ff[k+1]   <= dm_ff[k];
            neg_ff[k+1]  <= neg_ff[k];
            sat_ff[k+1]  <= sat_ff[k] | (take & HIGH);
            if (QL > 1) begin
               q_ff[k+1] <= QL'({q_ff[k], take});
            end else begin
               q_ff[k+1] <= QL'(take);
            end
         end
      end
   end

   // Sign and saturation of the final quotient.
   always_comb begin
      q_pos = {1'b0, q_ff[QB]};
      if (sat_ff[QB]) begin
         quot_in = neg_ff[QB] ? FMT_MIN : FMT_MAX;
      end else if (neg_ff[QB]) begin
         quot_in = -$signed(q_pos);
      end else begin
         quot_in = $signed(q_pos);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         quot_ff <= quot_in;
      end
   end

   assign quotient = quot_ff;

endmodule

@@ design/ray_box_slab_intersect_unit.sv @@
// Top level of the ray versus axis-aligned box slab intersection unit.
//
// A request on req_ carries one ray: origin and direction, signed fixed point.
// The box bounds sit in six registers written through the csr_ port; the user
// must write them only while the unit is idle, which the unit does not enforce.
// Each request gives exactly one response on rsp_: tuser is the hit flag, tdata
// holds the entry face and the entry and exit parameters, all zero on a miss.
// The six restoring dividers resolve one quotient bit per stage over
// COORD_WIDTH + FRAC_BITS + 1 stages; coordinates default to signed Q16.16.
// Throughput is one request per cycle while no response is stalled.
// The whole pipeline moves as one: it advances whenever the response register
// is empty or taken, so req_tready drops only while a response waits on a
// stalled receiver, and nothing is lost or repeated.
// Reset clears all valid bits and sets the box registers to zero.
module ray_box_slab_intersect_unit #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int FRAC_BITS   = rbsi_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z from bit 0 up
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] req_tdata,
   // entry_face, t_near, t_far from bit 0 up
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [((2*COORD_WIDTH+10)/8)*8-1:0] rsp_tdata,
   // hit
   output logic                              rsp_tuser,
   input  logic                              csr_wen,
   input  logic [rbsi_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [COORD_WIDTH-1:0]            csr_wdata
);

   localparam int W     = COORD_WIDTH;
   localparam int FW    = rbsi_pkg::FACE_W;
   localparam int QB    = W + 1 + FRAC_BITS;
   localparam int SL    = QB + 3;
   localparam int RSP_W = ((2*W+10)/8)*8;
   localparam longint EPS_RAW = ((64'd1 << FRAC_BITS) + 64'd5000) / 64'd10000;
   localparam longint EPS_VAL = (EPS_RAW == 0) ? 64'd1 : EPS_RAW;
   localparam logic signed [W+1:0] EPS_S = (W+2)'(EPS_VAL);
   localparam logic signed [W-1:0] FMT_MAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] FMT_MIN = {1'b1, {(W-1){1'b0}}};

   // Pipeline advance: everything moves unless a response is stalled.
   logic advance;
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;

   // Box registers.
   logic signed [W-1:0] lo_ff [0:2];
   logic signed [W-1:0] hi_ff [0:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < 3; a++) begin
            lo_ff[a] <= '0;
            hi_ff[a] <= '0;
         end
      end else if (csr_wen) begin
         case (csr_index)
            rbsi_pkg::CSR_BOX_MIN_X: lo_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Y: lo_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MIN_Z: lo_ff[2] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_X: hi_ff[0] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Y: hi_ff[1] <= csr_wdata;
            rbsi_pkg::CSR_BOX_MAX_Z: hi_ff[2] <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input stage: magnitudes of differences and directions, near-zero tests.
   logic signed [W-1:0] org [0:2];
   logic signed [W-1:0] dir [0:2];
   logic [W:0]          nlo_in [0:2];
   logic [W:0]          nhi_in [0:2];
   logic                neglo_in [0:2];
   logic                neghi_in [0:2];
   logic [W-1:0]        dm_in [0:2];
   rbsi_pkg::side_type  side_in;

   logic [W:0]          nlo_ff [0:2];
   logic [W:0]          nhi_ff [0:2];
   logic                neglo_ff [0:2];
   logic                neghi_ff [0:2];
   logic [W-1:0]        dm_ff [0:2];

   always_comb begin
      logic signed [W:0]   dlo;
      logic signed [W:0]   dhi;
      logic signed [W+1:0] dwide;
      side_in = '0;
      for (int a = 0; a < 3; a++) begin
         org[a] = req_tdata[a*W +: W];
         dir[a] = req_tdata[(a+3)*W +: W];
         dlo = {lo_ff[a][W-1], lo_ff[a]} - {org[a][W-1], org[a]};
         dhi = {hi_ff[a][W-1], hi_ff[a]} - {org[a][W-1], org[a]};
         nlo_in[a]   = dlo[W] ? (W+1)'(-dlo) : dlo;
         nhi_in[a]   = dhi[W] ? (W+1)'(-dhi) : dhi;
         neglo_in[a] = dlo[W] ^ dir[a][W-1];
         neghi_in[a] = dhi[W] ^ dir[a][W-1];
         dm_in[a]    = dir[a][W-1] ? W'(-dir[a]) : dir[a];
         dwide = {{2{dir[a][W-1]}}, dir[a]};
         side_in.zero_dir[a] = (dwide > -EPS_S) && (dwide < EPS_S);
         if (side_in.zero_dir[a] && ((org[a] < lo_ff[a]) || (org[a] > hi_ff[a]))) begin
            side_in.slab_miss = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < 3; a++) begin
            nlo_ff[a]   <= nlo_in[a];
            nhi_ff[a]   <= nhi_in[a];
            neglo_ff[a] <= neglo_in[a];
            neghi_ff[a] <= neghi_in[a];
            dm_ff[a]    <= dm_in[a];
         end
      end
   end

   // Valid bits and side flags delayed to match the dividers.
   logic               valid_ff [0:SL-1];
   rbsi_pkg::side_type side_ff  [0:SL-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SL; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         valid_ff[0] <= req_tvalid;
         for (int s = 1; s < SL; s++) begin
            valid_ff[s] <= valid_ff[s-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= side_in;
         for (int s = 1; s < SL; s++) begin
            side_ff[s] <= side_ff[s-1];
         end
      end
   end

   // Entry and exit quotients, two per axis.
   logic signed [W-1:0] t1 [0:2];
   logic signed [W-1:0] t2 [0:2];

   for (genvar a = 0; a < 3; a++) begin : g_axis
      rbsi_divider #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_lo (
         .clock   (clock),
         .advance (advance),
         .num_mag (nlo_ff[a]),
         .den_mag (dm_ff[a]),
         .neg     (neglo_ff[a]),
         .quotient(t1[a])
      );
      rbsi_divider #(.COORD_WIDTH(W), .FRAC_BITS(FRAC_BITS)) u_div_hi (
         .clock   (clock),
         .advance (advance),
         .num_mag (nhi_ff[a]),
         .den_mag (dm_ff[a]),
         .neg     (neghi_ff[a]),
         .quotient(t2[a])
      );
   end

   // Stage A: order each slab pair and pick its face.
   logic signed [W-1:0] na_in [0:2];
   logic signed [W-1:0] fa_in [0:2];
   logic [FW-1:0]       fc_in [0:2];
   logic signed [W-1:0] na_ff [0:2];
   logic signed [W-1:0] fa_ff [0:2];
   logic [FW-1:0]       fc_ff [0:2];
   logic                va_ff;
   logic                ma_ff;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         if (side_ff[SL-1].zero_dir[a]) begin
            na_in[a] = FMT_MIN;
            fa_in[a] = FMT_MAX;
            fc_in[a] = FW'(a);
         end else if (t1[a] > t2[a]) begin
            na_in[a] = t2[a];
            fa_in[a] = t1[a];
            fc_in[a] = FW'(a) + rbsi_pkg::FACE_MAX_OFFSET;
         end else begin
            na_in[a] = t1[a];
            fa_in[a] = t2[a];
            fc_in[a] = FW'(a);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
      end else if (advance) begin
         va_ff <= valid_ff[SL-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         ma_ff <= side_ff[SL-1].slab_miss;
         for (int a = 0; a < 3; a++) begin
            na_ff[a] <= na_in[a];
            fa_ff[a] <= fa_in[a];
            fc_ff[a] <= fc_in[a];
         end
      end
   end

   // Stage B: tighten the interval over the x and y axes.
   logic signed [W-1:0] tnb_in, tfb_in, tnb_ff, tfb_ff;
   logic [FW-1:0]       faceb_in, faceb_ff;
   logic                fsetb_in, fsetb_ff;
   logic                vb_ff, mb_ff;
   logic signed [W-1:0] nz_ff, fz_ff;
   logic [FW-1:0]       cz_ff;

   always_comb begin
      tnb_in   = FMT_MIN;
      tfb_in   = FMT_MAX;
      faceb_in = '0;
      fsetb_in = 1'b0;
      for (int a = 0; a < 2; a++) begin
         if (na_ff[a] > tnb_in) begin
            tnb_in   = na_ff[a];
            faceb_in = fc_ff[a];
            fsetb_in = 1'b1;
         end
         if (fa_ff[a] < tfb_in) begin
            tfb_in = fa_ff[a];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vb_ff <= 1'b0;
      end else if (advance) begin
         vb_ff <= va_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tnb_ff   <= tnb_in;
         tfb_ff   <= tfb_in;
         faceb_ff <= faceb_in;
         fsetb_ff <= fsetb_in;
         mb_ff    <= ma_ff;
         nz_ff    <= na_ff[2];
         fz_ff    <= fa_ff[2];
         cz_ff    <= fc_ff[2];
      end
   end

   // Stage C: the z axis, the final miss tests and the response register.
   logic signed [W-1:0] tnc, tfc;
   logic [FW-1:0]       facec;
   logic                fsetc, hit_in;
   logic                out_valid_ff, out_hit_ff;
   logic [FW-1:0]       out_face_ff;
   logic signed [W-1:0] out_near_ff, out_far_ff;

   always_comb begin
      tnc   = tnb_ff;
      tfc   = tfb_ff;
      facec = faceb_ff;
      fsetc = fsetb_ff;
      if (nz_ff > tnc) begin
         tnc   = nz_ff;
         facec = cz_ff;
         fsetc = 1'b1;
      end
      if (fz_ff < tfc) begin
         tfc = fz_ff;
      end
      hit_in = fsetc && !mb_ff && !(tnc > tfc) &&
               !($signed({{2{tfc[W-1]}}, tfc}) < EPS_S);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_hit_ff  <= hit_in;
         out_face_ff <= hit_in ? facec : '0;
         out_near_ff <= hit_in ? tnc : '0;
         out_far_ff  <= hit_in ? tfc : '0;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_hit_ff;
   assign rsp_tdata  = RSP_W'({out_far_ff, out_near_ff, out_face_ff});

`ifndef ASSERT_OFF
   // A hit always reports one of the six faces.
   a_face_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> out_face_ff <= FW'(5))
      else $error("entry face out of range on a hit");

   // A hit interval is never empty.
   a_hit_interval: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> out_near_ff <= out_far_ff)
      else $error("hit with t_near above t_far");

   // A miss carries all-zero data.
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("miss with nonzero response data");

   // A stalled response holds the whole pipeline.
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(vb_ff))
      else $error("pipeline moved during a stall");
`endif

endmodule

@@ tb/sv/testbench.sv @@
// Testbench of the ray versus axis-aligned box slab intersection unit.
`timescale 1ns / 100ps

module testbench;

   localparam int CW = rbsi_pkg::COORD_WIDTH_DEF;
   localparam int FB = rbsi_pkg::FRAC_BITS_DEF;
   localparam int IW = rbsi_pkg::CSR_INDEX_W;
   localparam int REQ_W = ((6*CW+7)/8)*8;
   localparam int RSP_W = ((2*CW+10)/8)*8;
   localparam int LATENCY = CW + FB + 6;
   localparam longint FMT_MAX = 64'sd2147483647;
   localparam longint FMT_MIN = -64'sd2147483648;
   localparam longint EPS = 7;
   localparam logic [IW-1:0] CSR_UNUSED = 3'd6;

   typedef struct packed {
      logic            hit;
      logic [2:0]      face;
      logic [CW-1:0]   t_near;
      logic [CW-1:0]   t_far;
   } hit_record_type;

   typedef struct {
      logic [CW-1:0]  org [3];
      logic [CW-1:0]  dir [3];
      logic           has_expect;
      hit_record_type expect_value;
   } ray_row_type;

   logic             clock;
   logic             reset;
   logic             req_tvalid;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata;
   logic             rsp_tvalid;
   logic             rsp_tready;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tuser;
   logic             csr_wen;
   logic [IW-1:0]    csr_index;
   logic [CW-1:0]    csr_wdata;

   // Box bounds as the predictor sees them: min x,y,z then max x,y,z.
   longint box_lo [3];
   longint box_hi [3];

   hit_record_type hits_pending [$];
   int mismatches;
   int rays_sent;
   int rays_hit;
   int rsp_count;
   int stall_cycles;
   logic rsp_taken;

   ray_box_slab_intersect_unit dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("Timeout waiting for responses.");
      $display("testbench NOT OK");
      $finish;
   end

   // Fixed-point quotient (a - b) / d with truncation and saturation.
   function automatic longint slab_quotient(longint a, longint b, longint d);
      logic [63:0] n, dm, qi, r, f, q;
      logic neg;
      n = (a >= b) ? 64'(a - b) : 64'(b - a);
      neg = (a < b) != (d < 0);
      dm = (d < 0) ? 64'(-d) : 64'(d);
      if (n == 0) return 0;
      qi = n / dm;
      r = n % dm;
      if (qi > (64'd1 << (CW - 1 - FB)))
         return neg ? FMT_MIN : FMT_MAX;
      f = 0;
      for (int k = 0; k < FB; k++) begin
         r = r << 1;
         f = f << 1;
         if (r >= dm) begin
            r = r - dm;
            f[0] = 1'b1;
         end
      end
      q = (qi << FB) + f;
      if (q >= (64'd1 << (CW - 1)))
         return neg ? FMT_MIN : FMT_MAX;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   // Slab test of one ray against the current box.
   function automatic hit_record_type slab_test(ray_row_type ray);
      hit_record_type res;
      longint tn, tf, t1, t2, o, d, tmp;
      int face;
      logic miss;
      int fc;
      tn = FMT_MIN;
      tf = FMT_MAX;
      face = -1;
      miss = 1'b0;
      res = '0;
      for (int i = 0; i < 3; i++) begin
         if (!miss) begin
            o = longint'($signed(ray.org[i]));
            d = longint'($signed(ray.dir[i]));
            if (d > -EPS && d < EPS) begin
               if (o < box_lo[i] || o > box_hi[i]) miss = 1'b1;
            end else begin
               t1 = slab_quotient(box_lo[i], o, d);
               t2 = slab_quotient(box_hi[i], o, d);
               fc = i;
               if (t1 > t2) begin
                  tmp = t1;
                  t1 = t2;
                  t2 = tmp;
                  fc = i + int'(rbsi_pkg::FACE_MAX_OFFSET);
               end
               if (t1 > tn) begin
                  tn = t1;
                  face = fc;
               end
               if (t2 < tf) tf = t2;
               if (tn > tf || tf < EPS) miss = 1'b1;
            end
         end
      end
      if (tn > tf || tf < EPS) miss = 1'b1;
      if (!miss && face >= 0) begin
         res.hit = 1'b1;
         res.face = 3'(face);
         res.t_near = tn[CW-1:0];
         res.t_far = tf[CW-1:0];
      end
      return res;
   endfunction

   function automatic logic [CW-1:0] rand_coord();
      case ($urandom_range(0, 5))
         0: return CW'($urandom_range(0, 40)) - CW'(20);           // near zero
         1: return $urandom();                                     // anything
         2: return {{8{1'b0}}, 24'($urandom())} ^ {CW{$urandom_range(0, 1) == 1}};
         default: return CW'(longint'($urandom_range(0, 32'h0020_0000)) - 64'sh10_0000);
      endcase
   endfunction

   task automatic write_register(logic [IW-1:0] idx, logic [CW-1:0] value);
      @(negedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_wen <= 1'b0;
      if (idx <= rbsi_pkg::CSR_BOX_MAX_Z) begin
         if (idx < rbsi_pkg::CSR_BOX_MAX_X) box_lo[idx] = longint'($signed(value));
         else box_hi[idx - rbsi_pkg::CSR_BOX_MAX_X] = longint'($signed(value));
      end
   endtask

   task automatic load_box(longint lo [3], longint hi [3]);
      for (int i = 0; i < 3; i++)
         write_register(rbsi_pkg::CSR_BOX_MIN_X + 3'(i), lo[i][CW-1:0]);
      for (int i = 0; i < 3; i++)
         write_register(rbsi_pkg::CSR_BOX_MAX_X + 3'(i), hi[i][CW-1:0]);
   endtask

   // Send one ray after a random gap and record its expected response.
   // The valid line stays high after acceptance until the next ray or a drain.
   task automatic send_ray(ray_row_type ray);
      int gap;
      gap = $urandom_range(0, 8);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tdata <= {ray.dir[2], ray.dir[1], ray.dir[0], ray.org[2], ray.org[1], ray.org[0]};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      hits_pending.insert(hits_pending.size(),
                          ray.has_expect ? ray.expect_value : slab_test(ray));
      rays_sent++;
      @(negedge clock);
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_tvalid <= 1'b0;
      while (hits_pending.size() != 0 && guard < 100000) begin
         @(posedge clock);
         guard++;
      end
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   // Receiver stalls: a new wait length is drawn after each response.
   always @(negedge clock) begin
      int wait_len;
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_cycles <= 0;
      end else if (rsp_taken) begin
         wait_len = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 8);
         rsp_tready <= (wait_len == 0);
         stall_cycles <= (wait_len > 0) ? wait_len - 1 : 0;
      end else if (stall_cycles > 0) begin
         rsp_tready <= 1'b0;
         stall_cycles <= stall_cycles - 1;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Response checker.
   always @(posedge clock) begin
      hit_record_type got, want;
      rsp_taken <= !reset && rsp_tvalid && rsp_tready;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.hit = rsp_tuser;
         got.face = rsp_tdata[2:0];
         got.t_near = rsp_tdata[3 +: CW];
         got.t_far = rsp_tdata[3+CW +: CW];
         rsp_count++;
         if (got.hit) rays_hit++;
         if (hits_pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("Response with nothing pending: %p", got);
         end else begin
            want = hits_pending.pop_front();
            if (got !== want || rsp_tdata[RSP_W-1:3+2*CW] !== '0) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("Mismatch: expected hit=%0b face=%0d near=%h far=%h",
                     want.hit, want.face, want.t_near, want.t_far);
                  $display("          got      hit=%0b face=%0d near=%h far=%h",
                     got.hit, got.face, got.t_near, got.t_far);
               end
            end
         end
      end
   end

   function automatic ray_row_type make_ray(longint ox, longint oy, longint oz,
                                            longint dx, longint dy, longint dz);
      ray_row_type r;
      r.org[0] = ox[CW-1:0];
      r.org[1] = oy[CW-1:0];
      r.org[2] = oz[CW-1:0];
      r.dir[0] = dx[CW-1:0];
      r.dir[1] = dy[CW-1:0];
      r.dir[2] = dz[CW-1:0];
      r.has_expect = 1'b0;
      r.expect_value = '0;
      return r;
   endfunction

   initial begin
      ray_row_type directed [$];
      ray_row_type r;
      longint lo [3];
      longint hi [3];
      longint one;
      one = 64'sh1_0000;
      mismatches = 0;
      rays_sent = 0;
      rays_hit = 0;
      rsp_count = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_wen = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      for (int i = 0; i < 3; i++) begin
         box_lo[i] = 0;
         box_hi[i] = 0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // After reset the box is a point at the origin; all zero directions give no face.
      r = make_ray(0, 0, 0, 0, 0, 0);
      r.has_expect = 1'b1;
      send_ray(r);
      r = make_ray(1, 0, 0, 0, 0, 0);
      r.has_expect = 1'b1;
      send_ray(r);
      drain();

      // Unit box from -1 to 1 on every axis; the unused index must be ignored.
      lo = '{-one, -one, -one};
      hi = '{one, one, one};
      load_box(lo, hi);
      write_register(CSR_UNUSED, 32'h7fff_ffff);

      // Directed table: every face, near-zero directions, saturation and extremes.
      directed.insert(directed.size(), make_ray(-4*one, 0, 0, one, 0, 0));
      directed.insert(directed.size(), make_ray(4*one, 0, 0, -one, 0, 0));
      directed.insert(directed.size(), make_ray(0, -4*one, 0, 0, one, 0));
      directed.insert(directed.size(), make_ray(0, 4*one, 0, 0, -one, 0));
      directed.insert(directed.size(), make_ray(0, 0, -4*one, 0, 0, one));
      directed.insert(directed.size(), make_ray(0, 0, 4*one, 0, 0, -one));
      directed.insert(directed.size(), make_ray(-4*one, 0, 0, 6, 0, 0));
      directed.insert(directed.size(), make_ray(-4*one, 0, 0, 7, 0, 0));
      directed.insert(directed.size(), make_ray(-4*one, 0, 0, -6, 0, one));
      directed.insert(directed.size(), make_ray(-4*one, 0, 0, -7, 0, 0));
      directed.insert(directed.size(), make_ray(4*one, 0, 0, one, 0, 0));
      directed.insert(directed.size(), make_ray(0, 0, 0, one, one, one));
      directed.insert(directed.size(),
         make_ray(FMT_MIN, FMT_MIN, FMT_MIN, FMT_MAX, FMT_MAX, FMT_MAX));
      directed.insert(directed.size(),
         make_ray(FMT_MAX, FMT_MAX, FMT_MAX, FMT_MIN, FMT_MIN, FMT_MIN));
      directed.insert(directed.size(), make_ray(FMT_MIN, 0, 0, 1, 0, 0));
      directed.insert(directed.size(), make_ray(-one, -one, -one, one, one, one));
      directed.insert(directed.size(), make_ray(2*one, 0, 0, 0, 0, 0));
      r = make_ray(0, 5*one, 0, 0, 0, 0);
      r.has_expect = 1'b1;
      directed.insert(directed.size(), r);
      foreach (directed[i]) send_ray(directed[i]);
      drain();

      // Inverted box and extreme bounds.
      lo = '{one, FMT_MIN, FMT_MIN};
      hi = '{-one, FMT_MAX, FMT_MAX};
      load_box(lo, hi);
      send_ray(make_ray(-4*one, 0, 0, one, 0, 0));
      send_ray(make_ray(0, 0, 0, 0, one, -one));
      drain();

      // Random phases, each with a new box.
      for (int phase = 0; phase < 8; phase++) begin
         for (int i = 0; i < 3; i++) begin
            if (phase == 7) begin
               lo[i] = FMT_MIN;
               hi[i] = FMT_MAX;
            end else begin
               lo[i] = longint'($signed(rand_coord()));
               hi[i] = ($urandom_range(0, 7) == 0) ? lo[i] - one
                       : lo[i] + longint'($urandom_range(1, 32'h0010_0000));
               if (hi[i] > FMT_MAX) hi[i] = FMT_MAX;
            end
         end
         load_box(lo, hi);
         for (int n = 0; n < 200; n++) begin
            r = make_ray(0, 0, 0, 0, 0, 0);
            for (int i = 0; i < 3; i++) begin
               r.org[i] = rand_coord();
               r.dir[i] = rand_coord();
               // Mostly aim the ray from outside toward the box.
               if ($urandom_range(0, 2) != 0 && phase != 7) begin
                  r.org[i] = CW'(lo[i] - longint'($urandom_range(0, 32'h0008_0000)));
                  r.dir[i] = CW'($urandom_range(0, 32'h0004_0000));
               end
            end
            send_ray(r);
         end
         drain();
      end

      $display("Sent %0d rays over several box settings, %0d responses, %0d hits.",
         rays_sent, rsp_count, rays_hit);
      if (mismatches == 0 && hits_pending.size() == 0) begin
         $display("testbench OK");
      end else begin
         $display("Failures: %0d mismatches, %0d responses missing.",
            mismatches, hits_pending.size());
         $display("testbench NOT OK");
      end
      $finish;
   end

endmodule

@@ sim.f @@
design/rbsi_pkg.sv
design/rbsi_divider.sv
design/ray_box_slab_intersect_unit.sv
tb/sv/testbench.sv
